/* hw/rtl/twsp_pkg.sv */
package twsp_pkg;

	localparam int MAX_TARGETS = 32;
	localparam int FRONT_SIZE  = 64;
	localparam int TIME_BITS   = 16;
	localparam int PROFIT_BITS = 16;

	localparam int IDX_W  = $clog2(MAX_TARGETS);
	localparam int CNT_W  = $clog2(MAX_TARGETS + 1);
	localparam int FA_W   = $clog2(FRONT_SIZE);
	localparam int LEN_W  = $clog2(FRONT_SIZE + 1);
	localparam int FIN_W  = TIME_BITS + 1;
	localparam int KEY_W  = TIME_BITS + 1;
	localparam int PROF_W = 21;

	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_SOLVE = 1'b1;

	typedef struct packed {
		logic [TIME_BITS-1:0]   rel;
		logic [TIME_BITS-1:0]   dl;
		logic [TIME_BITS-1:0]   dur;
		logic [PROFIT_BITS-1:0] gain;
	} target_t;

	typedef struct packed {
		logic [FIN_W-1:0]  fin;
		logic [PROF_W-1:0] prof;
	} front_t;

	typedef struct packed {
		logic            obs;
		logic [FA_W-1:0] idx;
	} link_t;

endpackage

/* hw/rtl/twsp_in_if.sv */
interface twsp_in_if;
	import twsp_pkg::*;
	logic                   valid;
	logic                   ready;
	logic                   op;
	logic [TIME_BITS-1:0]   release_time;
	logic [TIME_BITS-1:0]   deadline_time;
	logic [TIME_BITS-1:0]   duration;
	logic [PROFIT_BITS-1:0] gain;

	modport source (output valid, op, release_time, deadline_time, duration, gain,
		input ready);
	modport sink (input valid, op, release_time, deadline_time, duration, gain,
		output ready);
endinterface

/* hw/rtl/twsp_out_if.sv */
interface twsp_out_if;
	logic        valid;
	logic        ready;
	logic [4:0]  target_index;
	logic [15:0] start_time;
	logic [20:0] total_profit;
	logic        has_entry;
	logic        front_overflow;
	logic        last;

	modport source (output valid, target_index, start_time, total_profit, has_entry,
		front_overflow, last, input ready);
	modport sink (input valid, target_index, start_time, total_profit, has_entry,
		front_overflow, last, output ready);
endinterface

/* hw/rtl/time_window_schedule_pareto_dp_top.sv */
// Time-window observation scheduler, Pareto dynamic program.
// Channel "item" carries requests: op LOAD appends one target (release, deadline,
// duration, gain) to the table, op SOLVE computes the best schedule.
// Channel "result" returns one result per chosen observation in start order,
// or a single empty result; the final one has last set.
// Loads may follow back to back. A load with a full table is dropped.
// A solve runs an insertion sort over the order memory, then one merge pass
// per layer over the front (two front reads per merge step), then the best
// scan, the traceback and the emission of the results; emission waits
// while the receiver holds ready low.
// The block works on one solve at a time; item.ready is low from solve accept
// until the last result is taken. A stalled receiver holds the result register
// and the sequencer waits.
// Reset clears the target count, front lengths and the overflow flag. The
// memories need no clearing.
module time_window_schedule_pareto_dp_top import twsp_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	twsp_in_if.sink      item,
	twsp_out_if.source   result
);

	typedef enum logic [4:0] {
		S_IDLE, S_SORT_A, S_SORT_KEY, S_SORT_CHK, S_SORT_U, S_SORT_CMP,
		S_L_INIT, S_L_K, S_L_ID, S_L_TGT, S_M_RD, S_M_EV,
		S_B_RD, S_B_EV, S_T_INIT, S_T_RD, S_T_EV,
		S_E_INIT, S_E_RD, S_E_C, S_E_ID, S_E_TG, S_OUT
	} state_t;

	state_t state_q;

	// memories
	target_t           tgt_mem [MAX_TARGETS];
	logic [KEY_W-1:0]  key_mem [MAX_TARGETS];
	logic [IDX_W-1:0]  ord_mem [MAX_TARGETS];
	front_t            fr_mem  [2*FRONT_SIZE];
	link_t             lnk_mem [MAX_TARGETS*FRONT_SIZE];
	logic [IDX_W-1:0]  chs_mem [MAX_TARGETS];

	target_t           tgt_rd;
	logic [KEY_W-1:0]  key_rd;
	logic [IDX_W-1:0]  ord_rd;
	front_t            fr_rd_a, fr_rd_b;
	link_t             lnk_rd;
	logic [IDX_W-1:0]  chs_rd;

	logic [IDX_W-1:0]      tgt_ra, key_ra, ord_ra, ord_wa, chs_ra;
	logic [IDX_W-1:0]      ord_wd;
	logic                  ord_we, fr_we, lnk_we, chs_we;
	logic [FA_W:0]         fr_ra_a, fr_ra_b, fr_wa;
	front_t                fr_wd;
	logic [IDX_W+FA_W-1:0] lnk_ra, lnk_wa;
	link_t                 lnk_wd;

	// control registers
	logic [CNT_W-1:0]   cnt_q, a_q, b_q, k_q, nch_q;
	logic [KEY_W-1:0]   keya_q;
	logic [IDX_W-1:0]   u_q, id_q;
	target_t            tg_q;
	logic               cur_q, ovf_q;
	logic [LEN_W-1:0]   cur_len_q, nxt_len_q, i_q, j_q, e_q;
	logic [FIN_W-1:0]   last_fin_q, t_q;
	logic [PROF_W-1:0]  last_prof_q, bestp_q;
	logic [FA_W-1:0]    best_q, te_q;

	logic [4:0]  o_idx_q;
	logic [15:0] o_start_q;
	logic        o_has_q, o_last_q;

	// merge step
	logic [FIN_W-1:0]   mx;
	logic [FIN_W:0]     of;
	logic               take_obs, cand_ok, has_last, put_rep, put_app, put_ovf;
	logic [FIN_W-1:0]   cand_fin;
	logic [PROF_W-1:0]  cand_prof;
	link_t              cand_link;
	logic [FIN_W-1:0]   st;

	logic item_acc;
	assign item_acc   = item.valid && item.ready;
	assign item.ready = (state_q == S_IDLE);

	assign result.valid          = (state_q == S_OUT);
	assign result.target_index   = o_idx_q;
	assign result.start_time     = o_start_q;
	assign result.total_profit   = bestp_q;
	assign result.has_entry      = o_has_q;
	assign result.front_overflow = ovf_q;
	assign result.last           = o_last_q;

	// candidate and front insert decision
	always_comb begin
		mx        = (fr_rd_b.fin > FIN_W'(tg_q.rel)) ? fr_rd_b.fin : FIN_W'(tg_q.rel);
		of        = {1'b0, mx} + (FIN_W+1)'(tg_q.dur);
		take_obs  = (j_q < cur_len_q) && ((i_q >= cur_len_q) || ({1'b0, fr_rd_a.fin} > of));
		cand_ok   = take_obs ? (of <= (FIN_W+1)'(tg_q.dl)) : 1'b1;
		cand_fin  = take_obs ? of[FIN_W-1:0] : fr_rd_a.fin;
		cand_prof = take_obs ? fr_rd_b.prof + PROF_W'(tg_q.gain) : fr_rd_a.prof;
		cand_link = take_obs ? link_t'{obs: 1'b1, idx: j_q[FA_W-1:0]}
			: link_t'{obs: 1'b0, idx: i_q[FA_W-1:0]};
		has_last  = (nxt_len_q != '0);
		put_rep   = 1'b0;
		put_app   = 1'b0;
		put_ovf   = 1'b0;
		if (state_q == S_M_EV && cand_ok && !(has_last && cand_prof <= last_prof_q)) begin
			if (has_last && cand_fin == last_fin_q) begin
				put_rep = 1'b1;
			end else if (nxt_len_q < LEN_W'(FRONT_SIZE)) begin
				put_app = 1'b1;
			end else begin
				put_ovf = 1'b1;
			end
		end
		st = (t_q > FIN_W'(tgt_rd.rel)) ? t_q : FIN_W'(tgt_rd.rel);
	end

	// memory addresses and writes
	always_comb begin
		tgt_ra  = '0;
		key_ra  = a_q[IDX_W-1:0];
		ord_ra  = '0;
		ord_we  = 1'b0;
		ord_wa  = b_q[IDX_W-1:0];
		ord_wd  = a_q[IDX_W-1:0];
		chs_ra  = '0;
		chs_we  = 1'b0;
		fr_ra_a = {cur_q, i_q[FA_W-1:0]};
		fr_ra_b = {cur_q, j_q[FA_W-1:0]};
		fr_we   = put_rep || put_app;
		fr_wa   = put_rep ? {~cur_q, FA_W'(nxt_len_q - 1'b1)} : {~cur_q, nxt_len_q[FA_W-1:0]};
		fr_wd   = '{fin: cand_fin, prof: cand_prof};
		lnk_we  = put_rep || put_app;
		lnk_wa  = {k_q[IDX_W-1:0], fr_wa[FA_W-1:0]};
		lnk_wd  = cand_link;
		lnk_ra  = {IDX_W'(k_q - 1'b1), te_q};
		unique case (state_q)
			S_SORT_CHK: begin
				ord_ra = IDX_W'(b_q - 1'b1);
				ord_we = (b_q == '0);
			end
			S_SORT_U: key_ra = ord_rd;
			S_SORT_CMP: begin
				ord_we = 1'b1;
				if (key_rd > keya_q) begin
					ord_wd = u_q;
				end
			end
			S_L_INIT: begin
				fr_we = 1'b1;
				fr_wa = '0;
				fr_wd = '0;
			end
			S_L_K:   ord_ra = k_q[IDX_W-1:0];
			S_L_ID:  tgt_ra = ord_rd;
			S_B_RD:  fr_ra_a = {cur_q, e_q[FA_W-1:0]};
			S_T_EV:  chs_we = lnk_rd.obs;
			S_E_RD:  chs_ra = IDX_W'(k_q - 1'b1);
			S_E_C:   ord_ra = chs_rd;
			S_E_ID:  tgt_ra = ord_rd;
			S_E_TG:  tgt_ra = id_q;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (item_acc && item.op == OP_LOAD && cnt_q < CNT_W'(MAX_TARGETS)) begin
			tgt_mem[cnt_q[IDX_W-1:0]] <= '{rel: item.release_time, dl: item.deadline_time,
				dur: item.duration, gain: item.gain};
			key_mem[cnt_q[IDX_W-1:0]] <= KEY_W'(item.release_time) + KEY_W'(item.deadline_time);
		end
		tgt_rd <= tgt_mem[tgt_ra];
		key_rd <= key_mem[key_ra];
	end

	always_ff @(posedge clk) begin
		if (ord_we) begin
			ord_mem[ord_wa] <= ord_wd;
		end
		ord_rd <= ord_mem[ord_ra];
	end

	always_ff @(posedge clk) begin
		if (fr_we) begin
			fr_mem[fr_wa] <= fr_wd;
		end
		fr_rd_a <= fr_mem[fr_ra_a];
		fr_rd_b <= fr_mem[fr_ra_b];
	end

	always_ff @(posedge clk) begin
		if (lnk_we && state_q == S_M_EV) begin
			lnk_mem[lnk_wa] <= lnk_wd;
		end
		lnk_rd <= lnk_mem[lnk_ra];
	end

	always_ff @(posedge clk) begin
		if (chs_we) begin
			chs_mem[nch_q[IDX_W-1:0]] <= IDX_W'(k_q - 1'b1);
		end
		chs_rd <= chs_mem[chs_ra];
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			ovf_q       <= 1'b0;
			cur_len_q   <= '0;
			nxt_len_q   <= '0;
			a_q         <= '0;
			b_q         <= '0;
			k_q         <= '0;
			nch_q       <= '0;
			cur_q       <= 1'b0;
			i_q         <= '0;
			j_q         <= '0;
			e_q         <= '0;
			best_q      <= '0;
			te_q        <= '0;
			bestp_q     <= '0;
			t_q         <= '0;
			o_idx_q     <= '0;
			o_start_q   <= '0;
			o_has_q     <= 1'b0;
			o_last_q    <= 1'b0;
			keya_q      <= '0;
			u_q         <= '0;
			id_q        <= '0;
			tg_q        <= '0;
			last_fin_q  <= '0;
			last_prof_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (item_acc) begin
						if (item.op == OP_SOLVE) begin
							ovf_q   <= 1'b0;
							a_q     <= '0;
							state_q <= S_SORT_A;
						end else if (cnt_q < CNT_W'(MAX_TARGETS)) begin
							cnt_q <= cnt_q + 1'b1;
						end
					end
				end
				// insertion sort on release+deadline
				S_SORT_A: begin
					b_q     <= a_q;
					state_q <= (a_q == cnt_q) ? S_L_INIT : S_SORT_KEY;
				end
				S_SORT_KEY: begin
					keya_q  <= key_rd;
					state_q <= S_SORT_CHK;
				end
				S_SORT_CHK: begin
					if (b_q == '0) begin
						a_q     <= a_q + 1'b1;
						state_q <= S_SORT_A;
					end else begin
						state_q <= S_SORT_U;
					end
				end
				S_SORT_U: begin
					u_q     <= ord_rd;
					state_q <= S_SORT_CMP;
				end
				S_SORT_CMP: begin
					if (key_rd > keya_q) begin
						b_q     <= b_q - 1'b1;
						state_q <= S_SORT_CHK;
					end else begin
						a_q     <= a_q + 1'b1;
						state_q <= S_SORT_A;
					end
				end
				// front layers
				S_L_INIT: begin
					cur_q     <= 1'b0;
					cur_len_q <= LEN_W'(1);
					k_q       <= '0;
					e_q       <= '0;
					state_q   <= S_L_K;
				end
				S_L_K:  state_q <= (k_q == cnt_q) ? S_B_RD : S_L_ID;
				S_L_ID: state_q <= S_L_TGT;
				S_L_TGT: begin
					tg_q      <= tgt_rd;
					i_q       <= '0;
					j_q       <= '0;
					nxt_len_q <= '0;
					e_q       <= '0;
					state_q   <= S_M_RD;
				end
				S_M_RD: begin
					if (i_q >= cur_len_q && j_q >= cur_len_q) begin
						cur_q     <= ~cur_q;
						cur_len_q <= nxt_len_q;
						k_q       <= k_q + 1'b1;
						state_q   <= S_L_K;
					end else begin
						state_q <= S_M_EV;
					end
				end
				S_M_EV: begin
					if (take_obs) begin
						j_q <= j_q + 1'b1;
					end else begin
						i_q <= i_q + 1'b1;
					end
					if (put_rep) begin
						last_prof_q <= cand_prof;
					end
					if (put_app) begin
						last_fin_q  <= cand_fin;
						last_prof_q <= cand_prof;
						nxt_len_q   <= nxt_len_q + 1'b1;
					end
					if (put_ovf) begin
						ovf_q <= 1'b1;
					end
					state_q <= S_M_RD;
				end
				// best final state
				S_B_RD: state_q <= (e_q == cur_len_q) ? S_T_INIT : S_B_EV;
				S_B_EV: begin
					if (e_q == '0 || fr_rd_a.prof > bestp_q) begin
						best_q  <= e_q[FA_W-1:0];
						bestp_q <= fr_rd_a.prof;
					end
					e_q     <= e_q + 1'b1;
					state_q <= S_B_RD;
				end
				// traceback
				S_T_INIT: begin
					k_q     <= cnt_q;
					te_q    <= best_q;
					nch_q   <= '0;
					state_q <= S_T_RD;
				end
				S_T_RD: state_q <= (k_q == '0) ? S_E_INIT : S_T_EV;
				S_T_EV: begin
					if (lnk_rd.obs) begin
						nch_q <= nch_q + 1'b1;
					end
					te_q    <= lnk_rd.idx;
					k_q     <= k_q - 1'b1;
					state_q <= S_T_RD;
				end
				// emit in start order
				S_E_INIT: begin
					t_q <= '0;
					k_q <= nch_q;
					if (nch_q == '0) begin
						o_idx_q   <= '0;
						o_start_q <= '0;
						o_has_q   <= 1'b0;
						o_last_q  <= 1'b1;
						state_q   <= S_OUT;
					end else begin
						state_q <= S_E_RD;
					end
				end
				S_E_RD: state_q <= S_E_C;
				S_E_C:  state_q <= S_E_ID;
				S_E_ID: begin
					id_q    <= ord_rd;
					state_q <= S_E_TG;
				end
				S_E_TG: begin
					o_idx_q   <= 5'(id_q);
					o_start_q <= st[15:0];
					o_has_q   <= 1'b1;
					o_last_q  <= (k_q == CNT_W'(1));
					t_q       <= st + FIN_W'(tgt_rd.dur);
					k_q       <= k_q - 1'b1;
					state_q   <= S_OUT;
				end
				S_OUT: begin
					if (result.ready) begin
						state_q <= o_last_q ? S_IDLE : S_E_RD;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
